// ===== design/queue_with_move_to_front_unit_defines.svh =====
// Assertion macros shared by the checker of the move-to-front queue.
`ifndef QUEUE_WITH_MOVE_TO_FRONT_UNIT_DEFINES_SVH
`define QUEUE_WITH_MOVE_TO_FRONT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define QMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define QMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/qmf_pkg.sv =====
// Package with the request codes, status codes and controller states of the queue.
package qmf_pkg;

  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;
  localparam logic [1:0] MODE_MOVE = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MV_FIRST,
    ST_MV_SHIFT,
    ST_MV_LAST
  } state_t;

endpackage

// ===== design/queue_with_move_to_front_unit.sv =====
// Top level of the bounded FIFO with move-to-front, built around one entry memory.
//
// A request is given on mode, value and rank and is transferred at a rising edge where
// start is high and busy is low. Each request yields exactly one result, shown on
// result_value, status, is_empty and entry_count for one cycle while done is high.
// The receiver cannot stall; every result is taken in the cycle it is shown.
// Enqueue and every rejected request give their result in the cycle after the transfer.
// Dequeue and peek take one memory read with a registered output, answered from ST_READ.
// A move of rank 1 passes through ST_MV_FIRST only; a move of rank n above 1 passes
// through ST_MV_FIRST, ST_MV_SHIFT for each lower rank and ST_MV_LAST.
// The move walks the entries one per cycle through the single memory, reading the
// next lower rank while writing the current one. busy is low in the cycle done is high,
// so the next request can be transferred there. Reset clears the count, the front pointer
// and the controller; the memory is not cleared and only written entries are ever read.
module queue_with_move_to_front_unit #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic signed [31:0] value,
  input  logic [7:0]         rank,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [1:0]         status,
  output logic               is_empty,
  output logic [4:0]         entry_count
);
  import qmf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = (CW > 8) ? CW : 8;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata;
  logic [31:0]   moved;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr, waddr;
  logic          ren, wen;

  state_t        state, state_next;
  logic [CW-1:0] occupancy, occupancy_next;
  logic [AW-1:0] front_index, front_index_next;
  logic [AW-1:0] cur_slot, cur_slot_next;
  logic [CW-1:0] remaining, remaining_next;

  logic          res_fire;
  logic [31:0]   res_value;
  logic [1:0]    res_status;

  logic [7:0]    rank_m1;
  logic [AW-1:0] slot_tail, slot_newest, slot_rank;
  logic          q_empty, q_full, rank_bad;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
    logic [AW:0] lim;
    lim = (AW+1)'(DEPTH);
    return (sum >= lim) ? AW'(sum - lim) : AW'(sum);
  endfunction

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] s);
    return (s == '0) ? AW'(DEPTH - 1) : s - 1'b1;
  endfunction

  assign rank_m1     = rank - 8'd1;
  assign q_empty     = (occupancy == '0);
  assign q_full      = (occupancy == CW'(DEPTH));
  assign rank_bad    = (rank == 8'd0) || (RW'(rank) > RW'(occupancy));
  assign slot_tail   = wrap({1'b0, front_index} + (AW+1)'(occupancy));
  assign slot_newest = wrap({1'b0, front_index} + (AW+1)'(occupancy) - 1'b1);
  assign slot_rank   = wrap({1'b0, front_index} + (AW+1)'(rank_m1));
  assign busy        = (state != ST_IDLE);

  always_comb begin
    state_next       = state;
    occupancy_next   = occupancy;
    front_index_next = front_index;
    cur_slot_next    = cur_slot;
    remaining_next   = remaining;
    ren              = 1'b0;
    raddr            = '0;
    wen              = 1'b0;
    waddr            = '0;
    wdata            = rdata;
    res_fire         = 1'b0;
    res_value        = '0;
    res_status       = STAT_OK;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            MODE_ENQ: begin
              res_fire = 1'b1;
              if (q_full) begin
                res_status = STAT_FULL;
              end else begin
                wen            = 1'b1;
                waddr          = slot_tail;
                wdata          = value;
                occupancy_next = occupancy + 1'b1;
              end
            end
            MODE_DEQ: begin
              if (q_empty) begin
                res_fire   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                ren              = 1'b1;
                raddr            = front_index;
                front_index_next = (front_index == AW'(DEPTH - 1)) ? '0 : front_index + 1'b1;
                occupancy_next   = occupancy - 1'b1;
                state_next       = ST_READ;
              end
            end
            MODE_PEEK: begin
              if (q_empty) begin
                res_fire   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                ren        = 1'b1;
                raddr      = slot_newest;
                state_next = ST_READ;
              end
            end
            MODE_MOVE: begin
              if (q_empty) begin
                res_fire   = 1'b1;
                res_status = STAT_EMPTY;
              end else if (rank_bad) begin
                res_fire   = 1'b1;
                res_status = STAT_RANGE;
              end else begin
                ren            = 1'b1;
                raddr          = slot_rank;
                cur_slot_next  = slot_rank;
                remaining_next = CW'(rank_m1);
                state_next     = ST_MV_FIRST;
              end
            end
            default: begin
              res_fire = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        res_fire   = 1'b1;
        res_value  = rdata;
        state_next = ST_IDLE;
      end
      ST_MV_FIRST: begin
        if (remaining == '0) begin
          res_fire   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ren        = 1'b1;
          raddr      = prev_slot(cur_slot);
          state_next = ST_MV_SHIFT;
        end
      end
      ST_MV_SHIFT: begin
        wen            = 1'b1;
        waddr          = cur_slot;
        wdata          = rdata;
        cur_slot_next  = prev_slot(cur_slot);
        remaining_next = remaining - 1'b1;
        if (remaining == CW'(1)) begin
          state_next = ST_MV_LAST;
        end else begin
          ren   = 1'b1;
          raddr = prev_slot(prev_slot(cur_slot));
        end
      end
      ST_MV_LAST: begin
        wen        = 1'b1;
        waddr      = cur_slot;
        wdata      = moved;
        res_fire   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      occupancy   <= '0;
      front_index <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      occupancy   <= occupancy_next;
      front_index <= front_index_next;
      done        <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    cur_slot  <= cur_slot_next;
    remaining <= remaining_next;
    if (state == ST_MV_FIRST) begin
      moved <= rdata;
    end
    if (res_fire) begin
      result_value <= res_value;
      status       <= res_status;
      is_empty     <= (occupancy_next == '0);
      entry_count  <= 5'(occupancy_next);
    end
  end

endmodule

// ===== design/qmf_checker.sv =====
// Port-level checker of the move-to-front queue and its bind to the top level.
`include "queue_with_move_to_front_unit_defines.svh"

module qmf_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] result_value,
  input logic [1:0]         status,
  input logic               is_empty
);
  import qmf_pkg::*;

  // A transferred request either answers at once or keeps the unit busy.
  `QMF_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "request lost after transfer")
  // A result is only shown once the unit is free again.
  `QMF_ASSERT_NOW(a_done_not_busy, done, !busy, "result shown while busy")
  // An empty report carries a zero word and an empty queue.
  `QMF_ASSERT_NOW(a_empty_result, done && (status == STAT_EMPTY), is_empty && (result_value == 0), "empty status with data or entries")
  // A full report never comes with an empty queue.
  `QMF_ASSERT_NOW(a_full_not_empty, done && (status == STAT_FULL), !is_empty, "full status on an empty queue")

endmodule

bind queue_with_move_to_front_unit qmf_checker u_qmf_checker (.*);

// ===== test/tb_queue_with_move_to_front_unit.sv =====
// Testbench of the move-to-front queue: directed and random requests against a local predictor.
module tb_queue_with_move_to_front_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import qmf_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic signed [31:0] word;
    logic [1:0]         code;
    logic               none_left;
    logic [4:0]         held;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode = MODE_ENQ;
  logic signed [31:0] value = '0;
  logic [7:0]         rank = '0;
  logic               done;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic               is_empty;
  logic [4:0]         entry_count;

  logic [31:0]   slots [DEPTH];
  int            head_slot = 0;
  int            held_count = 0;
  queue_result_t pending_results [$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            burst_left = 0;

  queue_with_move_to_front_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .value(value),
    .rank(rank),
    .done(done),
    .result_value(result_value),
    .status(status),
    .is_empty(is_empty),
    .entry_count(entry_count)
  );

  always #1 clk = ~clk;

  function automatic int slot_at(int pos);
    return (head_slot + pos - 1) % DEPTH;
  endfunction

  function automatic queue_result_t apply_request(logic [1:0] op, logic signed [31:0] word,
                                                  logic [7:0] pos);
    queue_result_t r;
    logic [31:0]   moved;
    int            i;
    r.word = '0;
    r.code = STAT_OK;
    case (op)
      MODE_ENQ: begin
        if (held_count >= DEPTH) begin
          r.code = STAT_FULL;
        end else begin
          slots[slot_at(held_count + 1)] = word;
          held_count++;
        end
      end
      MODE_DEQ: begin
        if (held_count == 0) begin
          r.code = STAT_EMPTY;
        end else begin
          r.word = slots[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          held_count--;
        end
      end
      MODE_PEEK: begin
        if (held_count == 0) begin
          r.code = STAT_EMPTY;
        end else begin
          r.word = slots[slot_at(held_count)];
        end
      end
      default: begin
        if (held_count == 0) begin
          r.code = STAT_EMPTY;
        end else if (pos == 0 || pos > held_count) begin
          r.code = STAT_RANGE;
        end else begin
          moved = slots[slot_at(pos)];
          for (i = pos; i > 1; i--) begin
            slots[slot_at(i)] = slots[slot_at(i - 1)];
          end
          slots[head_slot] = moved;
        end
      end
    endcase
    r.none_left = (held_count == 0);
    r.held = held_count[4:0];
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the request is transferred.
  task automatic send_request(logic [1:0] op, logic signed [31:0] word, logic [7:0] pos);
    start <= 1'b1;
    mode <= op;
    value <= word;
    rank <= pos;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_results.push_back(apply_request(op, word, pos));
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    queue_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: value %0d status %0d", result_value, status);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (result_value !== e.word) begin
          $error("result_value: expected %0d, got %0d", e.word, result_value);
          error_count++;
        end
        if (status !== e.code) begin
          $error("status: expected %0d, got %0d", e.code, status);
          error_count++;
        end
        if (is_empty !== e.none_left) begin
          $error("is_empty: expected %0b, got %0b", e.none_left, is_empty);
          error_count++;
        end
        if (entry_count !== e.held) begin
          $error("entry_count: expected %0d, got %0d", e.held, entry_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_queue_with_move_to_front_unit failed");
      $finish;
    end
  end

  task automatic test_empty_queue();
    pace();
    send_request(MODE_DEQ, 32'sd7, 8'd1);
    pace();
    send_request(MODE_PEEK, -32'sd1, 8'd0);
    pace();
    send_request(MODE_MOVE, 32'sd0, 8'd5);
  endtask

  task automatic test_fill_to_full();
    logic signed [31:0] word;
    int                 i;
    for (i = 0; i < DEPTH; i++) begin
      case (i)
        0: word = 32'sh8000_0000;
        1: word = 32'sh7fff_ffff;
        2: word = 32'sd0;
        3: word = -32'sd1;
        4: word = 32'sh5555_5555;
        5: word = 32'shaaaa_aaaa;
        default: word = $urandom;
      endcase
      pace();
      send_request(MODE_ENQ, word, 8'hff);
    end
    pace();
    send_request(MODE_ENQ, 32'sh1234_5678, 8'd0);
  endtask

  task automatic test_move_ranks();
    pace();
    send_request(MODE_MOVE, 32'sd0, 8'd0);
    pace();
    send_request(MODE_MOVE, 32'sd0, 8'd255);
    pace();
    send_request(MODE_MOVE, 32'sd0, 8'd1);
    pace();
    send_request(MODE_MOVE, 32'sd0, 8'(DEPTH));
    pace();
    send_request(MODE_PEEK, 32'sd0, 8'd0);
    pace();
    send_request(MODE_DEQ, 32'sd0, 8'd0);
    pace();
    send_request(MODE_MOVE, 32'sd0, 8'(DEPTH));
    wait_until_drained();
  endtask

  task automatic test_random_traffic(int n_items);
    int         i;
    int         enq_pct;
    int         roll;
    logic [1:0] op;
    logic [7:0] pos;
    enq_pct = 50;
    for (i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 20;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
      end
      if (i == n_items / 2) begin
        wait_until_drained();
      end
      if ($urandom_range(0, 99) < enq_pct) begin
        op = MODE_ENQ;
      end else begin
        case ($urandom_range(0, 2))
          0: op = MODE_DEQ;
          1: op = MODE_PEEK;
          default: op = MODE_MOVE;
        endcase
      end
      roll = $urandom_range(0, 9);
      if (held_count > 0 && roll < 7) begin
        pos = 8'($urandom_range(1, held_count));
      end else if (roll < 8) begin
        pos = 8'd0;
      end else begin
        pos = 8'($urandom_range(0, 255));
      end
      pace();
      send_request(op, $urandom, pos);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_fill_to_full();
    test_move_ranks();
    test_random_traffic(800);
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_queue_with_move_to_front_unit passed");
    end else begin
      $display("tb_queue_with_move_to_front_unit failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/qmf_pkg.sv
design/queue_with_move_to_front_unit.sv
design/qmf_checker.sv
test/tb_queue_with_move_to_front_unit.sv
